[rtl/prst_pkg.sv]
package prst_pkg;

  // Pool geometry and field widths.
  localparam int unsigned Slots       = 64;
  localparam int unsigned MaxSegments = 32;
  localparam int unsigned SlotW       = 6;
  localparam int unsigned SegW        = 6;
  localparam int unsigned CountW      = 7;
  localparam int unsigned ReqW        = 8;
  localparam int unsigned IdW         = 32;
  localparam int unsigned KindW       = 3;

  // Reset value of the refill mark: half the pool.
  localparam logic [CountW-1:0] RefillReset = CountW'(Slots / 2);

  // Operation codes of an input transaction.
  typedef enum logic {
    OP_ALLOCATE = 1'b0,
    OP_COMPLETE = 1'b1
  } operation_e;

  // Result codes.
  typedef enum logic [KindW-1:0] {
    KIND_ALLOCATED = 3'd0,
    KIND_FULL      = 3'd1,
    KIND_COUNTED   = 3'd2,
    KIND_FINISHED  = 3'd3,
    KIND_BAD_SLOT  = 3'd4
  } result_kind_e;

  typedef struct packed {
    operation_e        operation;
    logic [ReqW-1:0]   requester;
    logic [IdW-1:0]    request_id;
    logic              is_write;
    logic [SegW-1:0]   segment_count;
    logic [SlotW-1:0]  slot_in;
    logic              segment_ok;
  } in_item_t;

  typedef struct packed {
    result_kind_e      result_kind;
    logic [SlotW-1:0]  slot_out;
    logic [ReqW-1:0]   resp_requester;
    logic [IdW-1:0]    resp_id;
    logic              resp_is_write;
    logic              resp_status;
    logic [CountW-1:0] outstanding;
    logic              below_refill;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;  // latch the transaction and launch the memory reads
    logic execute;  // update state and load the result register
  } prst_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free; // result register can take a new result this cycle
  } prst_status_t;

endpackage

[rtl/prst_ctrl.sv]
module prst_ctrl
  import prst_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  prst_status_t status_i,
  output prst_cmd_t    cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e state_q;

  // Sequencing: take a transaction, then finish it once the result register is free.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (status_i.out_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Commands follow directly from the state.
  assign in_ready_o    = (state_q == ST_IDLE);
  assign cmd_o.capture = (state_q == ST_IDLE) && in_valid_i;
  assign cmd_o.execute = (state_q == ST_EXEC) && status_i.out_free;

endmodule

[rtl/prst_datapath.sv]
module prst_datapath
  import prst_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  input  in_item_t          in_item_i,
  input  prst_cmd_t         cmd_i,
  output prst_status_t      status_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_item_o
);

  typedef struct packed {
    logic [ReqW-1:0] requester;
    logic [IdW-1:0]  request_id;
    logic            is_write;
  } rec_entry_t;

  typedef struct packed {
    logic            failed;
    logic [SegW-1:0] count;
  } rem_entry_t;

  // Memories: free ring, per-slot records and per-slot remaining counts.
  logic [SlotW-1:0] ring_mem [Slots];
  rec_entry_t       rec_mem  [Slots];
  rem_entry_t       rem_mem  [Slots];

  // Valid bits stand in for the reset contents of the ring and the counts.
  logic [Slots-1:0] ring_vld_q;
  logic [Slots-1:0] rem_vld_q;

  logic [CountW-1:0] refill_q;
  logic [SlotW-1:0]  free_head_q, free_head_d;
  logic [SlotW-1:0]  free_tail_q, free_tail_d;
  logic [CountW-1:0] busy_q, busy_d;

  in_item_t          item_q;
  logic [SlotW-1:0]  ring_rd_q;
  logic              ring_vld_rd_q;
  rec_entry_t        rec_rd_q;
  rem_entry_t        rem_rd_q;
  logic              rem_vld_rd_q;

  logic              out_valid_q;
  out_item_t         out_q, out_d;

  // Write ports, driven in the execute cycle.
  logic              ring_we;
  logic [SlotW-1:0]  ring_waddr;
  logic              rec_we;
  logic              rem_we;
  logic [SlotW-1:0]  rem_waddr;
  rem_entry_t        rem_wdata;

  logic [SlotW-1:0]  alloc_slot;
  rem_entry_t        rem_cur;
  logic [SegW-1:0]   seg_cnt;
  logic [SegW-1:0]   count_next;
  logic              failed_next;

  assign status_o.out_free = !out_valid_q || out_ready_i;

  // Refill mark register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      refill_q <= RefillReset;
    end else if (cfg_we_i) begin
      refill_q <= cfg_wdata_i;
    end
  end

  // Capture the transaction and launch the registered memory reads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q        <= in_item_i;
      ring_rd_q     <= ring_mem[free_head_q];
      ring_vld_rd_q <= ring_vld_q[free_head_q];
      rec_rd_q      <= rec_mem[in_item_i.slot_in];
      rem_rd_q      <= rem_mem[in_item_i.slot_in];
      rem_vld_rd_q  <= rem_vld_q[in_item_i.slot_in];
    end
  end

  // Memory writes.
  always_ff @(posedge clk_i) begin
    if (ring_we) begin
      ring_mem[ring_waddr] <= item_q.slot_in;
    end
    if (rec_we) begin
      rec_mem[alloc_slot] <= '{requester:  item_q.requester,
                               request_id: item_q.request_id,
                               is_write:   item_q.is_write};
    end
    if (rem_we) begin
      rem_mem[rem_waddr] <= rem_wdata;
    end
  end

  // Entries never written read as their reset contents.
  assign alloc_slot = ring_vld_rd_q ? ring_rd_q : free_head_q;
  assign rem_cur    = rem_vld_rd_q ? rem_rd_q : '0;

  // Clamp the segment count into one to the maximum.
  always_comb begin
    seg_cnt = item_q.segment_count;
    if (seg_cnt == '0) begin
      seg_cnt = SegW'(1);
    end
    if (seg_cnt > SegW'(MaxSegments)) begin
      seg_cnt = SegW'(MaxSegments);
    end
  end

  assign count_next  = rem_cur.count - SegW'(1);
  assign failed_next = rem_cur.failed | ~item_q.segment_ok;

  // Execute: decide the result and the state updates. A six-bit slot number
  // always lies inside the pool, so only a free slot makes a completion bad.
  always_comb begin
    free_head_d = free_head_q;
    free_tail_d = free_tail_q;
    busy_d      = busy_q;
    ring_we     = 1'b0;
    ring_waddr  = free_tail_q;
    rec_we      = 1'b0;
    rem_we      = 1'b0;
    rem_waddr   = item_q.slot_in;
    rem_wdata   = '{failed: failed_next, count: count_next};
    out_d       = '0;
    out_d.slot_out = item_q.slot_in;

    if (item_q.operation == OP_ALLOCATE) begin
      if (busy_q == CountW'(Slots)) begin
        out_d.result_kind = KIND_FULL;
        out_d.slot_out    = '0;
      end else begin
        out_d.result_kind = KIND_ALLOCATED;
        out_d.slot_out    = alloc_slot;
        rec_we            = cmd_i.execute;
        rem_we            = cmd_i.execute;
        rem_waddr         = alloc_slot;
        rem_wdata         = '{failed: 1'b0, count: seg_cnt};
        free_head_d       = (free_head_q == SlotW'(Slots - 1)) ? '0
                                                              : free_head_q + SlotW'(1);
        busy_d            = busy_q + CountW'(1);
      end
    end else if (rem_cur.count == '0) begin
      out_d.result_kind = KIND_BAD_SLOT;
    end else begin
      rem_we = cmd_i.execute;
      if (count_next == '0) begin
        out_d.result_kind    = KIND_FINISHED;
        out_d.resp_requester = rec_rd_q.requester;
        out_d.resp_id        = rec_rd_q.request_id;
        out_d.resp_is_write  = rec_rd_q.is_write;
        out_d.resp_status    = failed_next;
        ring_we              = cmd_i.execute;
        free_tail_d          = (free_tail_q == SlotW'(Slots - 1)) ? '0
                                                                 : free_tail_q + SlotW'(1);
        if (busy_q != '0) begin
          busy_d = busy_q - CountW'(1);
        end
      end else begin
        out_d.result_kind = KIND_COUNTED;
      end
    end

    out_d.outstanding  = busy_d;
    out_d.below_refill = (busy_d < refill_q);
  end

  // Control registers: indices, count, valid bits and the result flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      free_head_q <= '0;
      free_tail_q <= '0;
      busy_q      <= '0;
      ring_vld_q  <= '0;
      rem_vld_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.execute) begin
        free_head_q <= free_head_d;
        free_tail_q <= free_tail_d;
        busy_q      <= busy_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (ring_we) begin
        ring_vld_q[ring_waddr] <= 1'b1;
      end
      if (rem_we) begin
        rem_vld_q[rem_waddr] <= 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

[rtl/pending_request_slot_tracker_unit.sv]
// Channel   Direction  Handshake            Payload
// in        input      in_valid_i/ready_o   in_item_i (in_item_t)
// out       output     out_valid_o/ready_i  out_item_o (out_item_t)
// cfg       input      cfg_we_i             cfg_wdata_i (refill mark)
//
// Each transaction is handled in a capture state, which launches the synchronous
// reads of the ring, record and count memories, and an execute state, which updates them and loads the result.
// Reset clears all indices and counts at once; there is no clearing pass.
// A new transaction is taken while a result still waits; the second one holds
// in its execute cycle until the result register is free.
module pending_request_slot_tracker_unit
  import prst_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CountW-1:0] cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  in_item_t          in_item_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_item_o
);

  prst_cmd_t    cmd;
  prst_status_t status;

  // Controller.
  prst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Datapath.
  prst_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_item_i   (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o)
  );

endmodule

[verif/tb_pending_request_slot_tracker_unit.sv]
module tb_pending_request_slot_tracker_unit;
  import prst_pkg::*;

  localparam int unsigned StallLimit = 4000;
  localparam int unsigned PhaseItems = 280;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } directed_row_t;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CountW-1:0] cfg_wdata_i;
  logic              in_valid_i;
  logic              in_ready_o;
  in_item_t          in_item_i;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  out_item_t         out_item_o;

  // Mirror of the tracker state, kept in step with accepted transactions.
  logic [SlotW-1:0]  free_slot_ring [Slots];
  logic [SlotW-1:0]  ring_take;
  logic [SlotW-1:0]  ring_give;
  logic [CountW-1:0] live_count;
  logic [ReqW-1:0]   owner_tag   [Slots];
  logic [IdW-1:0]    owner_id    [Slots];
  logic              owner_write [Slots];
  logic              owner_failed[Slots];
  logic [SegW-1:0]   segs_left   [Slots];
  logic [CountW-1:0] refill_mark;

  out_item_t     pending_results[$];
  directed_row_t directed_rows[14];
  int            send_idle_pct;
  int            recv_idle_pct;
  int            mismatches = 0;
  int            quiet_cycles = 0;
  bit            filling = 1'b1;

  pending_request_slot_tracker_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_item_i  (in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o (out_item_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Applies one transaction to the mirror and returns the result it must give.
  function automatic out_item_t track_request(in_item_t it);
    out_item_t        res;
    logic [SlotW-1:0] s;
    logic [SegW-1:0]  segs;
    res = '0;
    if (it.operation == OP_ALLOCATE) begin
      if (live_count == Slots) begin
        res.result_kind = KIND_FULL;
      end else begin
        // Zero counts as one segment; long requests saturate.
        segs = it.segment_count;
        if (segs == 0) segs = SegW'(1);
        if (segs > MaxSegments) segs = SegW'(MaxSegments);
        s = free_slot_ring[ring_take];
        ring_take = ring_take + 1'b1;
        live_count = live_count + 1'b1;
        owner_tag[s] = it.requester;
        owner_id[s] = it.request_id;
        owner_write[s] = it.is_write;
        owner_failed[s] = 1'b0;
        segs_left[s] = segs;
        res.result_kind = KIND_ALLOCATED;
        res.slot_out = s;
      end
    end else begin
      s = it.slot_in;
      res.slot_out = s;
      if (segs_left[s] == 0) begin
        res.result_kind = KIND_BAD_SLOT;
      end else begin
        if (!it.segment_ok) owner_failed[s] = 1'b1;
        segs_left[s] = segs_left[s] - 1'b1;
        if (segs_left[s] == 0) begin
          // Last segment: report the request and hand the slot back.
          res.resp_requester = owner_tag[s];
          res.resp_id = owner_id[s];
          res.resp_is_write = owner_write[s];
          res.resp_status = owner_failed[s];
          free_slot_ring[ring_give] = s;
          ring_give = ring_give + 1'b1;
          if (live_count > 0) live_count = live_count - 1'b1;
          res.result_kind = KIND_FINISHED;
        end else begin
          res.result_kind = KIND_COUNTED;
        end
      end
    end
    res.outstanding = live_count;
    res.below_refill = live_count < refill_mark;
    return res;
  endfunction

  function automatic in_item_t alloc_item(logic [ReqW-1:0] req, logic [IdW-1:0] id,
                                          logic wr, logic [SegW-1:0] segs);
    in_item_t it;
    it = '0;
    it.operation = OP_ALLOCATE;
    it.requester = req;
    it.request_id = id;
    it.is_write = wr;
    it.segment_count = segs;
    return it;
  endfunction

  function automatic in_item_t done_item(logic [SlotW-1:0] slot, logic ok);
    in_item_t it;
    it = '0;
    it.operation = OP_COMPLETE;
    it.slot_in = slot;
    it.segment_ok = ok;
    return it;
  endfunction

  function automatic out_item_t result_of(result_kind_e kind, logic [SlotW-1:0] slot,
                                          logic [ReqW-1:0] req, logic [IdW-1:0] id,
                                          logic wr, logic st, logic [CountW-1:0] outs,
                                          logic below);
    out_item_t res;
    res.result_kind = kind;
    res.slot_out = slot;
    res.resp_requester = req;
    res.resp_id = id;
    res.resp_is_write = wr;
    res.resp_status = st;
    res.outstanding = outs;
    res.below_refill = below;
    return res;
  endfunction

  // Random transaction, biased towards filling or draining the pool.
  function automatic in_item_t random_item();
    in_item_t         it;
    int               roll;
    int               seg_roll;
    int               start;
    logic [SlotW-1:0] probe;
    it.requester = ReqW'($urandom);
    it.request_id = $urandom;
    it.is_write = 1'($urandom);
    it.slot_in = SlotW'($urandom);
    it.segment_ok = ($urandom_range(9) != 0);
    seg_roll = $urandom_range(99);
    if (seg_roll < 80) it.segment_count = SegW'($urandom_range(1, 3));
    else if (seg_roll < 88) it.segment_count = SegW'($urandom_range(4, 12));
    else if (seg_roll < 92) it.segment_count = '0;
    else if (seg_roll < 95) it.segment_count = SegW'(MaxSegments);
    else if (seg_roll < 98) it.segment_count = SegW'($urandom_range(33, 63));
    else it.segment_count = SegW'($urandom);
    roll = $urandom_range(99);
    if (roll < (filling ? 85 : 10)) begin
      it.operation = OP_ALLOCATE;
    end else begin
      it.operation = OP_COMPLETE;
      // Mostly aim at a live request; otherwise keep the random slot.
      if (roll < 95) begin
        start = $urandom_range(Slots - 1);
        for (int k = 0; k < Slots; k++) begin
          probe = SlotW'((start + k) % Slots);
          if (segs_left[probe] != 0) begin
            it.slot_in = probe;
            break;
          end
        end
      end
    end
    return it;
  endfunction

  // Presents one transaction after an optional gap and records its result.
  task automatic send_item(in_item_t it, logic typed, out_item_t want);
    out_item_t predicted;
    int        gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct && gap < 200) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_item_i <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predicted = track_request(it);
    pending_results.push_back(typed ? want : predicted);
  endtask

  // Lets the block drain, then writes the refill mark.
  task automatic write_refill(logic [CountW-1:0] value);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    refill_mark = value;
  endtask

  task automatic check_field(string name, logic [IdW-1:0] exp_v, logic [IdW-1:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endtask

  // Receiver: stalls at random according to the current phase.
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare every result transaction with the oldest outstanding prediction.
  always @(posedge clk_i) begin
    out_item_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, actual %h",
                 $time, out_item_o);
        mismatches++;
      end else begin
        want = pending_results.pop_front();
        check_field("result_kind", want.result_kind, out_item_o.result_kind);
        check_field("slot_out", want.slot_out, out_item_o.slot_out);
        check_field("resp_requester", want.resp_requester, out_item_o.resp_requester);
        check_field("resp_id", want.resp_id, out_item_o.resp_id);
        check_field("resp_is_write", want.resp_is_write, out_item_o.resp_is_write);
        check_field("resp_status", want.resp_status, out_item_o.resp_status);
        check_field("outstanding", want.outstanding, out_item_o.outstanding);
        check_field("below_refill", want.below_refill, out_item_o.below_refill);
      end
    end
  end

  // Count cycles in which neither channel moves a transaction.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    wait (rst_ni === 1'b1);
    while (quiet_cycles < StallLimit) @(posedge clk_i);
    $display("%0t: no transaction for %0d cycles", $time, StallLimit);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    logic [CountW-1:0] marks[5];
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    in_item_i = '0;
    send_idle_pct = 14;
    recv_idle_pct = 83;
    marks = '{RefillReset, 7'd0, 7'd64, 7'd127, 7'd1};

    // Reset state of the mirror: every slot free and in order.
    for (int i = 0; i < Slots; i++) begin
      free_slot_ring[SlotW'(i)] = SlotW'(i);
      segs_left[SlotW'(i)] = '0;
      owner_tag[SlotW'(i)] = '0;
      owner_id[SlotW'(i)] = '0;
      owner_write[SlotW'(i)] = 1'b0;
      owner_failed[SlotW'(i)] = 1'b0;
    end
    ring_take = '0;
    ring_give = '0;
    live_count = '0;
    refill_mark = RefillReset;

    // Directed transactions; rows with typed results are plain at a glance.
    directed_rows[0] = '{done_item(0, 1'b1), 1'b1,
                         result_of(KIND_BAD_SLOT, 0, 0, 0, 0, 0, 0, 1)};
    directed_rows[1] = '{done_item(63, 1'b0), 1'b1,
                         result_of(KIND_BAD_SLOT, 63, 0, 0, 0, 0, 0, 1)};
    directed_rows[2] = '{alloc_item(8'hFF, 32'hFFFF_FFFF, 1'b1, 6'd0), 1'b1,
                         result_of(KIND_ALLOCATED, 0, 0, 0, 0, 0, 1, 1)};
    directed_rows[3] = '{done_item(0, 1'b1), 1'b1,
                         result_of(KIND_FINISHED, 0, 8'hFF, 32'hFFFF_FFFF, 1, 0, 0, 1)};
    directed_rows[4] = '{alloc_item(8'h00, 32'h0, 1'b0, 6'd63), 1'b1,
                         result_of(KIND_ALLOCATED, 1, 0, 0, 0, 0, 1, 1)};
    directed_rows[5] = '{done_item(1, 1'b0), 1'b0, '0};
    directed_rows[6] = '{alloc_item(8'h5A, 32'h1234_5678, 1'b0, 6'd1), 1'b1,
                         result_of(KIND_ALLOCATED, 2, 0, 0, 0, 0, 2, 1)};
    directed_rows[7] = '{alloc_item(8'h01, 32'h1, 1'b1, 6'd32), 1'b0, '0};
    directed_rows[8] = '{done_item(2, 1'b0), 1'b1,
                         result_of(KIND_FINISHED, 2, 8'h5A, 32'h1234_5678, 0, 1, 2, 1)};
    directed_rows[9] = '{done_item(2, 1'b1), 1'b1,
                         result_of(KIND_BAD_SLOT, 2, 0, 0, 0, 0, 2, 1)};
    directed_rows[10] = '{alloc_item(8'h80, 32'h8000_0000, 1'b1, 6'd2), 1'b0, '0};
    directed_rows[11] = '{done_item(4, 1'b1), 1'b0, '0};
    directed_rows[12] = '{done_item(4, 1'b0), 1'b0, '0};
    directed_rows[13] = '{alloc_item(8'hA5, 32'h0F0F_0F0F, 1'b0, 6'd33), 1'b0, '0};

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
    end

    // Random phases, each with its own refill mark; phases 0-1 and 2-3 share an idling pattern, phase 4 never idles.
    for (int phase = 0; phase < 5; phase++) begin
      if (phase > 0) begin
        send_idle_pct = (phase < 2) ? 14 : (phase < 4) ? 83 : 0;
        recv_idle_pct = (phase < 2) ? 83 : (phase < 4) ? 14 : 0;
        write_refill(marks[3'(phase)]);
      end
      repeat (PhaseItems) begin
        if ($urandom_range(59) == 0) filling = !filling;
        send_item(random_item(), 1'b0, '0);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/prst_pkg.sv
rtl/prst_ctrl.sv
rtl/prst_datapath.sv
rtl/pending_request_slot_tracker_unit.sv
verif/tb_pending_request_slot_tracker_unit.sv
